/* design/melody_tone_sequencer_unit_macros.svh */
// assertion macros for the melody tone sequencer
// used by files that carry concurrent checks, no other dependencies
`ifndef MELODY_TONE_SEQUENCER_UNIT_MACROS_SVH
`define MELODY_TONE_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define MTS_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mts_pkg.sv */
// shared types, codes and melody tables for the melody tone sequencer
// no dependencies
package mts_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_KEY    = 2'd1,
        OP_WALL   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        KEY_NONE = 3'd0,
        KEY_SW1  = 3'd1,
        KEY_SW2  = 3'd2,
        KEY_SW3  = 3'd3,
        KEY_SW7  = 3'd4,
        KEY_SW5  = 3'd5
    } t_key;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_stat;

    localparam int unsigned TAB_SONGS     = 3;
    localparam int unsigned TAB_NOTES     = 9;
    localparam int unsigned BASE_CLOCK    = 14000000;
    localparam int unsigned WALL_PRESCALE = 1 << 10;
    localparam int unsigned WALL_DIV      = BASE_CLOCK / WALL_PRESCALE;
    localparam int unsigned MS_PER_S      = 1000;
    localparam int unsigned LIMIT_W       = 17;
    localparam int unsigned VOL_MAX       = 8;
    localparam int unsigned VOL_RESET     = 4;
    localparam int unsigned SW1_BIT       = 0;
    localparam int unsigned SW2_BIT       = 1;
    localparam int unsigned SW3_BIT       = 2;
    localparam int unsigned SW5_BIT       = 4;
    localparam int unsigned SW7_BIT       = 6;

    localparam int unsigned TONE_FREQ [TAB_SONGS][TAB_NOTES] = '{
        '{100, 200, 300, 400, 500, 600, 700, 800, 900},
        '{900, 800, 700, 600, 500, 400, 300, 200, 100},
        '{1000, 1200, 0, 0, 0, 0, 0, 0, 0}
    };

    localparam int unsigned TONE_DUR [TAB_SONGS][TAB_NOTES] = '{
        '{100, 100, 100, 100, 100, 100, 100, 100, 100},
        '{100, 100, 100, 100, 100, 100, 100, 100, 100},
        '{100, 200, 0, 0, 0, 0, 0, 0, 0}
    };

    localparam int unsigned SONG_LEN [TAB_SONGS] = '{9, 9, 2};

    function automatic int unsigned tone_freq(int unsigned s, int unsigned i);
        int unsigned v;
        v = 0;
        if (s < TAB_SONGS && i < TAB_NOTES) begin
            v = TONE_FREQ[s][i];
        end
        return v;
    endfunction

    function automatic int unsigned tone_dur(int unsigned s, int unsigned i);
        int unsigned v;
        v = 0;
        if (s < TAB_SONGS && i < TAB_NOTES) begin
            v = TONE_DUR[s][i];
        end
        return v;
    endfunction

    function automatic int unsigned song_len(int unsigned s);
        int unsigned v;
        v = 0;
        if (s < TAB_SONGS) begin
            v = SONG_LEN[s];
        end
        return v;
    endfunction

endpackage

/* design/mts_if.sv */
// handshake channels of the melody tone sequencer: event items in, results out
// no dependencies
interface mts_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] key_pins;

    modport source (output valid, output op, output key_pins, input ready);
    modport sink (input valid, input op, input key_pins, output ready);
endinterface

interface mts_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] dac_level;
    logic [7:0] led_bar;
    logic       playing;
    logic [1:0] song_number;
    logic [3:0] note_number;

    modport source (output valid, output dac_level, output led_bar, output playing,
                    output song_number, output note_number, input ready);
    modport sink (input valid, input dac_level, input led_bar, input playing,
                  input song_number, input note_number, output ready);
endinterface

/* design/mts_ram.sv */
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/mts_mod_unit.sv */
// bit-serial remainder unit, one numerator bit per cycle
// depends on mts_pkg for the status struct
module mts_mod_unit
    import mts_pkg::*;
#(
    parameter int NUM_W = 18,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_clear,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_mod_stat        o_stat,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_den, n_den;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W:0]   w_trial;

    always_comb begin
        n_busy  = r_busy;
        n_done  = r_done;
        n_cnt   = r_cnt;
        n_num   = r_num;
        n_den   = r_den;
        n_rem   = r_rem;
        w_trial = {r_rem, r_num[NUM_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = CNT_W'(NUM_W);
            n_num  = i_num;
            n_den  = i_den;
            n_rem  = '0;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = DEN_W'(w_trial - {1'b0, r_den});
            end else begin
                n_rem = w_trial[DEN_W-1:0];
            end
            n_num = r_num << 1;
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_clear) begin
            n_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

/* design/melody_tone_sequencer_unit.sv */
// melody tone sequencer top level: note ram, execute stage, result register
// depends on mts_pkg, mts_if, mts_ram, mts_mod_unit and the assertion macros
//
//   channel    dir  modport  payload
//   i_item     in   sink     op, key_pins
//   o_result   out  source   dac_level, led_bar, playing, song_number, note_number
//
// one item per cycle while the execute stage is not held; the note entry is read
// from ram in the accept cycle into the ram output register, where the execute
// stage uses it, with the address forwarded from the state the item ahead leaves.
// the first sample tick of a note whose period is at or below the carried phase
// stays in the execute stage until the remainder unit has reduced the phase.
// after reset the note ram is loaded entry by entry, with ready low.
// a stalled result holds the execute stage; one further item is still taken.

`include "melody_tone_sequencer_unit_macros.svh"

module melody_tone_sequencer_unit
    import mts_pkg::*;
#(
    parameter int SONG_COUNT  = 3,
    parameter int NOTES_MAX   = 9,
    parameter int SAMPLE_RATE = 44100
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mts_in_if.sink    i_item,
    mts_out_if.source o_result
);

    localparam int DEPTH  = SONG_COUNT * NOTES_MAX;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (NOTES_MAX > 1) ? $clog2(NOTES_MAX) : 1;
    localparam int SEL_W  = (SONG_COUNT > 1) ? $clog2(SONG_COUNT) : 1;
    localparam int PER_W  = $clog2(SAMPLE_RATE + 1);
    localparam int ENT_W  = PER_W + LIMIT_W;

    // note table: period in samples and note length in wall ticks
    logic [ENT_W-1:0] w_tab [DEPTH];
    logic [IDX_W:0]   w_len [SONG_COUNT];

    for (genvar g = 0; g < DEPTH; g++) begin : g_tab
        localparam int unsigned SI   = g / NOTES_MAX;
        localparam int unsigned NI   = g % NOTES_MAX;
        localparam int unsigned FREQ = tone_freq(SI, NI);
        localparam int unsigned DUR  = tone_dur(SI, NI);
        localparam int unsigned PER  = (FREQ == 0 || FREQ > SAMPLE_RATE) ? 1 :
                                       SAMPLE_RATE / ((FREQ == 0) ? 1 : FREQ);
        localparam int unsigned LIM  = (DUR * WALL_DIV + MS_PER_S - 1) / MS_PER_S;
        assign w_tab[g] = {PER_W'(PER), LIMIT_W'(LIM)};
    end

    for (genvar s = 0; s < SONG_COUNT; s++) begin : g_len
        localparam int unsigned LEN = (song_len(s) > NOTES_MAX) ? NOTES_MAX : song_len(s);
        assign w_len[s] = (IDX_W + 1)'(LEN);
    end

    // load pass
    logic              r_load_done;
    logic [ADDR_W-1:0] r_load_idx;

    // execute stage item
    logic       r_s1_valid;
    logic [1:0] r_s1_op;
    logic [7:0] r_s1_pins;

    // block state
    logic [7:0]       r_pressed_prev, n_pressed_prev;
    logic [7:0]       r_pressed_now, n_pressed_now;
    t_key             r_typed, n_typed;
    logic [3:0]       r_volume, n_volume;
    logic             r_play, n_play;
    logic [SEL_W-1:0] r_song, n_song;
    logic [IDX_W-1:0] r_note, n_note;
    logic [PER_W-1:0] r_phase, n_phase;
    logic [15:0]      r_wall, n_wall;
    logic             r_wall_run, n_wall_run;
    logic [4:0]       r_held, n_held;
    logic             r_out_valid;

    // execute datapath
    logic [ENT_W-1:0]   w_rd_data;
    logic [PER_W-1:0]   w_per;
    logic [LIMIT_W-1:0] w_limit;
    logic [1:0]         w_key_song;
    logic               w_press;
    logic [SEL_W-1:0]   w_s_song;
    logic [IDX_W-1:0]   w_s_note;
    logic               w_s_play;
    logic [15:0]        w_s_wall;
    logic               w_in_time;
    logic [PER_W-1:0]   w_q, w_q2, w_q3;
    logic [1:0]         w_step;
    logic [PER_W:0]     w_p1;
    logic               w_ph_big;
    logic [PER_W-1:0]   w_ph_next;
    logic [4:0]         w_held;
    logic [IDX_W:0]     w_note_inc;
    logic               w_last;
    logic [7:0]         w_now, w_new;
    t_key               w_key;
    logic               w_need_mod;
    logic               w_exec_fire;
    logic               w_accept;

    // remainder unit
    t_mod_stat        w_mod_stat;
    logic             w_mod_start;
    logic [PER_W-1:0] w_mod_rem;

    // forwarded read address
    logic [1:0]        w_fw_key_song;
    logic              w_fw_press;
    logic [SEL_W-1:0]  w_rd_song;
    logic [IDX_W-1:0]  w_rd_note;
    logic [ADDR_W-1:0] w_rd_addr;

    assign w_per   = w_rd_data[ENT_W-1 -: PER_W];
    assign w_limit = w_rd_data[LIMIT_W-1:0];

    // sample tick view of the state after a pending song press
    always_comb begin
        w_key_song = 2'(r_typed) - 2'd1;
        w_press    = (r_typed inside {KEY_SW1, KEY_SW2, KEY_SW3}) &&
                     (32'(w_key_song) < SONG_COUNT);
        w_s_song   = w_press ? SEL_W'(w_key_song) : r_song;
        w_s_note   = w_press ? '0 : r_note;
        w_s_play   = w_press | r_play;
        w_s_wall   = w_press ? '0 : r_wall;
        w_in_time  = LIMIT_W'(w_s_wall) < w_limit;
    end

    // staircase step and phase advance
    always_comb begin
        w_q  = w_per >> 2;
        w_q2 = w_q << 1;
        w_q3 = w_q2 + w_q;
        if (r_phase < w_q) begin
            w_step = 2'd0;
        end else if (r_phase < w_q2) begin
            w_step = 2'd1;
        end else if (r_phase < w_q3) begin
            w_step = 2'd2;
        end else begin
            w_step = 2'd3;
        end
        w_p1     = {1'b0, r_phase} + (PER_W + 1)'(1);
        w_ph_big = r_phase >= w_per;
        if (w_ph_big) begin
            w_ph_next = w_mod_rem;
        end else if (w_p1 == {1'b0, w_per}) begin
            w_ph_next = '0;
        end else begin
            w_ph_next = w_p1[PER_W-1:0];
        end
        w_held     = 5'(6'(r_volume) * 6'(w_step));
        w_note_inc = {1'b0, w_s_note} + (IDX_W + 1)'(1);
        w_last     = w_note_inc >= w_len[w_s_song];
    end

    // key edge detection by priority
    always_comb begin
        w_now = ~r_s1_pins;
        w_new = w_now & ~r_pressed_now;
        if (w_new[SW1_BIT]) begin
            w_key = KEY_SW1;
        end else if (w_new[SW2_BIT]) begin
            w_key = KEY_SW2;
        end else if (w_new[SW3_BIT]) begin
            w_key = KEY_SW3;
        end else if (w_new[SW7_BIT]) begin
            w_key = KEY_SW7;
        end else if (w_new[SW5_BIT]) begin
            w_key = KEY_SW5;
        end else begin
            w_key = KEY_NONE;
        end
    end

    assign w_need_mod  = r_s1_valid && (r_s1_op == OP_SAMPLE) && w_s_play &&
                         w_in_time && w_ph_big;
    assign w_exec_fire = r_s1_valid && (!r_out_valid || o_result.ready) &&
                         (!w_need_mod || w_mod_stat.done);
    assign w_mod_start = w_need_mod && !w_mod_stat.busy && !w_mod_stat.done;

    // next state of the execute stage
    always_comb begin
        n_pressed_prev = r_pressed_prev;
        n_pressed_now  = r_pressed_now;
        n_typed        = r_typed;
        n_volume       = r_volume;
        n_play         = r_play;
        n_song         = r_song;
        n_note         = r_note;
        n_phase        = r_phase;
        n_wall         = r_wall;
        n_wall_run     = r_wall_run;
        n_held         = r_held;
        if (w_exec_fire) begin
            case (r_s1_op)
                OP_SAMPLE: begin
                    n_typed    = KEY_NONE;
                    n_song     = w_s_song;
                    n_note     = w_s_note;
                    n_play     = w_s_play;
                    n_wall     = w_s_wall;
                    n_wall_run = w_press | r_wall_run;
                    if (w_s_play) begin
                        if (w_in_time) begin
                            n_phase = w_ph_next;
                            n_held  = w_held;
                        end else begin
                            n_wall = '0;
                            if (w_last) begin
                                n_note     = '0;
                                n_play     = 1'b0;
                                n_wall_run = 1'b0;
                            end else begin
                                n_note = w_note_inc[IDX_W-1:0];
                            end
                        end
                    end
                end
                OP_KEY: begin
                    n_pressed_prev = r_pressed_now;
                    n_pressed_now  = w_now;
                    n_typed        = w_key;
                    if (w_key == KEY_SW5 && r_volume != 4'd0) begin
                        n_volume = r_volume - 4'd1;
                    end
                    if (w_key == KEY_SW7 && r_volume < 4'(VOL_MAX)) begin
                        n_volume = r_volume + 4'd1;
                    end
                end
                OP_WALL: begin
                    if (r_wall_run) begin
                        n_wall = r_wall + 16'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // read address for the incoming item, from the state the item ahead leaves
    always_comb begin
        w_fw_key_song = 2'(n_typed) - 2'd1;
        w_fw_press    = (n_typed inside {KEY_SW1, KEY_SW2, KEY_SW3}) &&
                        (32'(w_fw_key_song) < SONG_COUNT) &&
                        (i_item.op == OP_SAMPLE);
        w_rd_song     = w_fw_press ? SEL_W'(w_fw_key_song) : n_song;
        w_rd_note     = w_fw_press ? '0 : n_note;
        w_rd_addr     = ADDR_W'(32'(w_rd_song) * NOTES_MAX + 32'(w_rd_note));
    end

    assign i_item.ready = r_load_done && (!r_s1_valid || w_exec_fire);
    assign w_accept     = i_item.valid && i_item.ready;

    mts_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (!r_load_done),
        .i_waddr (r_load_idx),
        .i_wdata (w_tab[r_load_idx]),
        .i_re    (w_accept),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    mts_mod_unit #(
        .NUM_W (PER_W + 1),
        .DEN_W (PER_W)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_clear (w_exec_fire),
        .i_num   (w_p1),
        .i_den   (w_per),
        .o_stat  (w_mod_stat),
        .o_rem   (w_mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_done    <= 1'b0;
            r_load_idx     <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_pressed_prev <= 8'hff;
            r_pressed_now  <= 8'hff;
            r_typed        <= KEY_NONE;
            r_volume       <= 4'(VOL_RESET);
            r_play         <= 1'b0;
            r_song         <= '0;
            r_note         <= '0;
            r_phase        <= '0;
            r_wall         <= '0;
            r_wall_run     <= 1'b1;
            r_held         <= '0;
        end else begin
            if (!r_load_done) begin
                if (r_load_idx == ADDR_W'(DEPTH - 1)) begin
                    r_load_done <= 1'b1;
                end else begin
                    r_load_idx <= r_load_idx + ADDR_W'(1);
                end
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_exec_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (w_exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            r_pressed_prev <= n_pressed_prev;
            r_pressed_now  <= n_pressed_now;
            r_typed        <= n_typed;
            r_volume       <= n_volume;
            r_play         <= n_play;
            r_song         <= n_song;
            r_note         <= n_note;
            r_phase        <= n_phase;
            r_wall         <= n_wall;
            r_wall_run     <= n_wall_run;
            r_held         <= n_held;
        end
        if (w_accept) begin
            r_s1_op   <= i_item.op;
            r_s1_pins <= i_item.key_pins;
        end
    end

    // the result is the state after the transfer
    assign o_result.valid       = r_out_valid;
    assign o_result.dac_level   = r_held;
    assign o_result.led_bar     = 8'(8'hff << r_volume);
    assign o_result.playing     = r_play;
    assign o_result.song_number = 2'(r_song);
    assign o_result.note_number = 4'(r_note);

    `MTS_ASSERT(a_idle_note_zero, i_clk, i_rst_n, !r_play, r_note == '0, "note index set while idle")
    `MTS_ASSERT_NEXT(a_stage_kept, i_clk, i_rst_n, r_s1_valid && !w_exec_fire, r_s1_valid, "execute item lost")
    `MTS_ASSERT(a_volume_range, i_clk, i_rst_n, 1'b1, r_volume <= 4'(VOL_MAX), "volume above limit")
    `MTS_ASSERT(a_song_range, i_clk, i_rst_n, 1'b1, 32'(r_song) < SONG_COUNT, "song index out of range")
    `MTS_ASSERT_NEXT(a_mod_consumed, i_clk, i_rst_n, w_mod_stat.done && w_exec_fire, !w_mod_stat.done, "remainder reused")

endmodule

/* dv/testbench.sv */
// testbench for melody_tone_sequencer_unit: directed power-up, key, volume,
// playback and backpressure, then random traffic, checked by a cycle-free model
// depends on mts_pkg, mts_if and the unit itself
`timescale 1ns / 100ps

module testbench
    import mts_pkg::*;
();

    localparam int unsigned SAMPLE_HZ      = 44100;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam int unsigned RANDOM_EVENTS  = 100;
    localparam int unsigned PHASE_TICKS    = 48;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_TAIL     = 40;
    localparam int unsigned MAX_REPORTS    = 20;
    localparam int unsigned SONG_KEY_BIT [TAB_SONGS] = '{SW1_BIT, SW2_BIT, SW3_BIT};

    typedef struct packed {
        logic [4:0] dac_level;
        logic [7:0] led_bar;
        logic       playing;
        logic [1:0] song_number;
        logic [3:0] note_number;
    } t_tone_out;

    typedef enum int unsigned {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HALF,
        STALL_HEAVY
    } t_stall;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mts_in_if  item_if ();
    mts_out_if result_if ();

    melody_tone_sequencer_unit #(
        .SONG_COUNT  (TAB_SONGS),
        .NOTES_MAX   (TAB_NOTES),
        .SAMPLE_RATE (SAMPLE_HZ)
    ) i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    // sequencer model state
    logic [7:0]  m_keys_last = 8'hff;
    logic [7:0]  m_keys_cur  = 8'hff;
    t_key        m_pending   = KEY_NONE;
    logic [3:0]  m_vol       = 4'(VOL_RESET);
    logic        m_active    = 1'b0;
    logic [1:0]  m_song      = 2'd0;
    logic [3:0]  m_note      = 4'd0;
    int unsigned m_phase     = 0;
    logic [15:0] m_wall      = 16'd0;
    logic        m_wall_run  = 1'b1;
    logic [4:0]  m_level     = 5'd0;

    t_tone_out   tone_results_due [$];
    int unsigned burst_left     = 0;
    int unsigned hold_request   = 0;
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;

    function automatic t_tone_out advance_sequencer(input logic [1:0] op,
                                                    input logic [7:0] pins);
        int unsigned s, n, freq, period, quarter, stair, elapsed_ms, len;
        logic [7:0] fresh;
        t_tone_out r;
        case (op)
            OP_SAMPLE: begin
                s = TAB_SONGS;
                case (m_pending)
                    KEY_SW1: s = 0;
                    KEY_SW2: s = 1;
                    KEY_SW3: s = 2;
                    default: ;
                endcase
                if (s < TAB_SONGS) begin
                    m_note     = 4'd0;
                    m_song     = 2'(s);
                    m_active   = 1'b1;
                    m_wall     = 16'd0;
                    m_wall_run = 1'b1;
                end
                m_pending = KEY_NONE;
                if (m_active) begin
                    s = m_song % TAB_SONGS;
                    n = m_note % TAB_NOTES;
                    elapsed_ms = (int'(m_wall) * MS_PER_S) / WALL_DIV;
                    if (elapsed_ms < TONE_DUR[s][n]) begin
                        freq = TONE_FREQ[s][n];
                        period = (freq != 0 && freq <= SAMPLE_HZ) ? SAMPLE_HZ / freq : 1;
                        quarter = period / 4;
                        if (m_phase < quarter)            stair = 0;
                        else if (m_phase < 2 * quarter)   stair = 1;
                        else if (m_phase < 3 * quarter)   stair = 2;
                        else                              stair = 3;
                        m_phase = (m_phase + 1) % period;
                        m_level = 5'(m_vol * stair);
                    end else begin
                        len = SONG_LEN[s];
                        if (len > TAB_NOTES) len = TAB_NOTES;
                        m_wall = 16'd0;
                        n++;
                        if (n >= len) begin
                            n          = 0;
                            m_active   = 1'b0;
                            m_wall_run = 1'b0;
                        end
                        m_note = 4'(n);
                    end
                end
            end
            OP_KEY: begin
                m_keys_last = m_keys_cur;
                m_keys_cur  = ~pins;
                fresh       = m_keys_cur & ~m_keys_last;
                if (fresh[SW1_BIT])      m_pending = KEY_SW1;
                else if (fresh[SW2_BIT]) m_pending = KEY_SW2;
                else if (fresh[SW3_BIT]) m_pending = KEY_SW3;
                else if (fresh[SW7_BIT]) m_pending = KEY_SW7;
                else if (fresh[SW5_BIT]) m_pending = KEY_SW5;
                else                     m_pending = KEY_NONE;
                if (m_pending == KEY_SW5 && m_vol > 0) m_vol--;
                if (m_pending == KEY_SW7 && m_vol < VOL_MAX) m_vol++;
            end
            OP_WALL: begin
                if (m_wall_run) m_wall++;
            end
            default: ;
        endcase
        r.dac_level   = m_level;
        r.led_bar     = 8'hff << m_vol;
        r.playing     = m_active;
        r.song_number = m_song;
        r.note_number = m_note;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_seen, field, got, want);
    endtask

    task automatic send_event(input logic [1:0] op, input logic [7:0] pins);
        int unsigned gap;
        logic [7:0] bus_pins;
        bus_pins = (op == OP_KEY) ? pins : 8'($urandom);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        item_if.valid    <= 1'b1;
        item_if.op       <= op;
        item_if.key_pins <= bus_pins;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        burst_left--;
        tone_results_due.push_back(advance_sequencer(op, bus_pins));
    endtask

    task automatic wait_for_results;
        item_if.valid <= 1'b0;
        burst_left = 0;
        while (tone_results_due.size() != 0) @(posedge clk);
    endtask

    task automatic key_tap(input logic [7:0] held);
        send_event(OP_KEY, ~held);
        send_event(OP_KEY, 8'hff);
    endtask

    // press, let the next sample tick take it, then release
    task automatic start_song(input int unsigned s);
        send_event(OP_KEY, ~(8'd1 << SONG_KEY_BIT[s]));
        send_event(OP_SAMPLE, 8'h00);
        send_event(OP_KEY, 8'hff);
    endtask

    task automatic play_notes(input int unsigned stop_note);
        while (m_active && m_note < stop_note) begin
            repeat ($urandom_range(20, 60)) send_event(OP_WALL, 8'h00);
            repeat ($urandom_range(1, 3)) send_event(OP_SAMPLE, 8'h00);
            if ($urandom_range(0, 15) == 0)
                key_tap($urandom_range(0, 1) ? 8'd1 << SW5_BIT : 8'd1 << SW7_BIT);
        end
    endtask

    task automatic test_power_up;
        send_event(OP_WALL, 8'h00);
        send_event(OP_UNUSED, 8'h00);
        send_event(OP_SAMPLE, 8'h00);
        send_event(OP_KEY, 8'hff);
    endtask

    task automatic test_volume_keys;
        repeat (5) key_tap(8'd1 << SW5_BIT);
        repeat (9) key_tap(8'd1 << SW7_BIT);
        // both volume keys at once: raise has priority
        key_tap((8'd1 << SW5_BIT) | (8'd1 << SW7_BIT));
        key_tap(8'd1 << SW5_BIT);
        key_tap(8'd1 << SW7_BIT);
    endtask

    task automatic test_pending_keys;
        // song press lost to a release before the tick
        send_event(OP_KEY, 8'h00);
        send_event(OP_KEY, 8'hff);
        send_event(OP_SAMPLE, 8'h00);
        // volume key only cleared by the tick
        send_event(OP_KEY, ~(8'd1 << SW7_BIT));
        send_event(OP_SAMPLE, 8'h00);
        send_event(OP_KEY, 8'hff);
        // every key at once: SW1 wins and starts a song
        send_event(OP_KEY, 8'h00);
        send_event(OP_SAMPLE, 8'h00);
        send_event(OP_KEY, 8'hff);
        send_event(OP_SAMPLE, 8'h00);
        send_event(OP_WALL, 8'h00);
        send_event(OP_SAMPLE, 8'h00);
    endtask

    task automatic test_song_playback;
        // a long period leaves a large phase for the short one of the next song
        start_song(0);
        repeat (PHASE_TICKS) send_event(OP_SAMPLE, 8'h00);
        start_song(2);
        // first note runs out and the next one takes over
        play_notes(1);
        repeat (8) send_event(OP_SAMPLE, 8'h00);
    endtask

    task automatic test_backpressure;
        wait_for_results;
        hold_request = HOLD_CYCLES;
        repeat (40) send_event(2'($urandom_range(0, 3)), 8'($urandom));
        wait_for_results;
        repeat (20) send_event(2'($urandom_range(0, 3)), 8'($urandom));
    endtask

    task automatic test_random_traffic;
        int unsigned events, roll, k;
        events = 0;
        while (events < RANDOM_EVENTS) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                k = $urandom_range(0, TAB_SONGS - 1);
                send_event(OP_KEY, ~(8'd1 << SONG_KEY_BIT[k]));
                // sometimes spoilt by another key transfer before the tick
                if ($urandom_range(0, 3) == 0) begin
                    send_event(OP_KEY, 8'($urandom));
                    events++;
                end
                send_event(OP_SAMPLE, 8'h00);
                send_event(OP_KEY, 8'hff);
                events += 3;
            end else if (roll < 20) begin
                k = $urandom_range(1, 20);
                repeat (k) send_event(OP_WALL, 8'h00);
                events += k;
            end else if (roll < 55) begin
                k = $urandom_range(1, 8);
                repeat (k) send_event(OP_SAMPLE, 8'h00);
                events += k;
            end else if (roll < 67) begin
                key_tap($urandom_range(0, 1) ? 8'd1 << SW5_BIT : 8'd1 << SW7_BIT);
                events += 2;
            end else if (roll < 90) begin
                send_event(OP_KEY, 8'($urandom));
                events++;
            end else if (roll < 95) begin
                send_event(OP_UNUSED, 8'h00);
                events++;
            end else begin
                send_event(OP_WALL, 8'h00);
                events++;
            end
        end
    endtask

    initial begin
        forever #5 clk = ~clk;
    end

    // result receiver: stall pattern in windows, plus requested hold-offs
    initial begin : receiver
        t_stall mode;
        int unsigned window, hold_left;
        mode      = STALL_NONE;
        window    = 0;
        hold_left = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (window == 0) begin
                window = $urandom_range(32, 256);
                mode   = t_stall'($urandom_range(0, 3));
            end
            window--;
            if (hold_left != 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else begin
                case (mode)
                    STALL_NONE:  result_if.ready <= 1'b1;
                    STALL_LIGHT: result_if.ready <= ($urandom_range(0, 3) != 0);
                    STALL_HALF:  result_if.ready <= ($urandom_range(0, 1) != 0);
                    default:     result_if.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin : result_checker
        t_tone_out want;
        forever begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready) begin
                if (tone_results_due.size() == 0) begin
                    report_mismatch("no result due", 16'd0, 16'd0);
                end else begin
                    want = tone_results_due.pop_front();
                    if (result_if.dac_level !== want.dac_level)
                        report_mismatch("dac_level", result_if.dac_level, want.dac_level);
                    if (result_if.led_bar !== want.led_bar)
                        report_mismatch("led_bar", result_if.led_bar, want.led_bar);
                    if (result_if.playing !== want.playing)
                        report_mismatch("playing", result_if.playing, want.playing);
                    if (result_if.song_number !== want.song_number)
                        report_mismatch("song_number", result_if.song_number,
                                        want.song_number);
                    if (result_if.note_number !== want.note_number)
                        report_mismatch("note_number", result_if.note_number,
                                        want.note_number);
                end
                results_seen++;
            end
        end
    end

    // covers reset, ram load, hold-offs and the execute stage stall many times over
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL melody_tone_sequencer_unit");
        $finish;
    end

    initial begin
        item_if.valid    <= 1'b0;
        item_if.op       <= OP_SAMPLE;
        item_if.key_pins <= 8'hff;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_power_up;
        test_volume_keys;
        test_pending_keys;
        test_song_playback;
        test_backpressure;
        test_random_traffic;

        wait_for_results;
        repeat (DRAIN_TAIL) @(posedge clk);
        if (tone_results_due.size() != 0)
            report_mismatch("results missing", 16'(tone_results_due.size()), 16'd0);
        if (mismatch_count == 0)
            $display("PASS melody_tone_sequencer_unit");
        else
            $display("FAIL melody_tone_sequencer_unit");
        $finish;
    end

endmodule
